// ----- rtl/core/esr_pkg.sv -----
// Shared widths, constants and controller/datapath interface types for expected_score_residual.
`timescale 1ns / 1ps
`default_nettype none

package esr_pkg;

   localparam int PROB_W     = 17;
   localparam int RESP_W     = 4;
   localparam int FRAC_W     = 16;
   localparam int EXP_W      = 20;
   localparam int VAR_W      = 22;
   localparam int RES_W      = 21;
   localparam int STD_W      = 24;
   localparam int S2_W       = 24;
   localparam int VQ_W       = 40;
   localparam int ROOT_W     = 20;
   localparam int REM_W      = 21;
   localparam int MAG_W      = 36;
   localparam int SQRT_STEPS = 20;
   localparam int DIV_STEPS  = 36;
   localparam int STEP_W     = 6;

   localparam logic [EXP_W-1:0] S1_MAX  = {EXP_W{1'b1}};
   localparam logic [S2_W-1:0]  S2_MAX  = {S2_W{1'b1}};
   localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};
   localparam logic [STD_W-1:0] STD_POS_MAX = {1'b0, {(STD_W-1){1'b1}}};
   localparam logic [STD_W-1:0] STD_NEG_MAX = {1'b1, {(STD_W-1){1'b0}}};

   typedef struct packed {
      logic acc;
      logic square;
      logic var_load;
      logic sqrt_step;
      logic div_load;
      logic div_step;
      logic out_load;
   } esr_cmd_type;

   typedef struct packed {
      logic last_skip;
      logic vq_zero;
      logic out_busy;
   } esr_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/esr_ctrl.sv -----
// Sequencing state machine: accumulate, square, variance, square root, divide, output.
`timescale 1ns / 1ps
`default_nettype none

module esr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_is_last,
   output logic                    req_ready,
   input  esr_pkg::esr_status_type status,
   output esr_pkg::esr_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_VAR,
      ST_SQRT,
      ST_DIV_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [esr_pkg::STEP_W-1:0]   step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.acc = 1'b1;
               if (req_is_last) begin
                  state_in = status.last_skip ? ST_FINISH : ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_VAR;
         end
         ST_VAR: begin
            cmd.var_load = 1'b1;
            step_in      = '0;
            state_in     = status.vq_zero ? ST_FINISH : ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == esr_pkg::STEP_W'(esr_pkg::SQRT_STEPS - 1)) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == esr_pkg::STEP_W'(esr_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/esr_dp.sv -----
// Datapath: run accumulators, variance, bit-serial square root and divider, output register.
`timescale 1ns / 1ps
`default_nettype none

module esr_dp #(
   parameter int MAX_CATEGORIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [esr_pkg::PROB_W-1:0]          req_prob,
   input  logic                                req_is_last,
   input  logic [esr_pkg::RESP_W-1:0]          req_response,
   input  logic                                req_response_missing,
   input  esr_pkg::esr_cmd_type                cmd,
   output esr_pkg::esr_status_type             status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [esr_pkg::EXP_W-1:0]           rsp_expected,
   output logic [esr_pkg::VAR_W-1:0]           rsp_variance,
   output logic signed [esr_pkg::RES_W-1:0]    rsp_residual,
   output logic signed [esr_pkg::STD_W-1:0]    rsp_std_residual,
   output logic                                rsp_missing,
   output logic                                rsp_zero_variance,
   output logic                                rsp_too_many
);

   localparam int CNT_W  = $clog2(MAX_CATEGORIES + 1);
   localparam int KSQ_W  = 2 * CNT_W;
   localparam int PW1    = CNT_W + esr_pkg::PROB_W;
   localparam int PW2    = KSQ_W + esr_pkg::PROB_W;
   localparam int SUM1_W = ((PW1 >= esr_pkg::EXP_W) ? PW1 : esr_pkg::EXP_W) + 1;
   localparam int SUM2_W = ((PW2 >= esr_pkg::S2_W) ? PW2 : esr_pkg::S2_W) + 1;
   localparam int VQ_W   = esr_pkg::VQ_W;
   localparam int REM_W  = esr_pkg::REM_W;
   localparam int ROOT_W = esr_pkg::ROOT_W;
   localparam int MAG_W  = esr_pkg::MAG_W;
   localparam int RES_W  = esr_pkg::RES_W;
   localparam int STD_W  = esr_pkg::STD_W;

   // run state
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [KSQ_W-1:0]              ksq_ff, ksq_in;
   logic [esr_pkg::EXP_W-1:0]     s1_ff, s1_in;
   logic [esr_pkg::S2_W-1:0]      s2_ff, s2_in;
   logic                          ovf_ff, ovf_in;
   logic [esr_pkg::RESP_W-1:0]    resp_ff;
   logic                          miss_ff;
   logic                          tm_ff;

   // closing arithmetic
   logic [VQ_W-1:0]               sq_ff;
   logic [esr_pkg::VAR_W-1:0]     var_ff;
   logic                          zv_ff;
   logic [RES_W-1:0]              res_ff;
   logic [VQ_W-1:0]               rad_ff;
   logic [REM_W-1:0]              rem_ff;
   logic [ROOT_W-1:0]             root_ff;
   logic [MAG_W-1:0]              num_ff;
   logic [ROOT_W-1:0]             drem_ff;
   logic [MAG_W-1:0]              quo_ff;
   logic                          out_valid_ff;

   logic                          cnt_full;
   logic [PW1-1:0]                prod1;
   logic [PW2-1:0]                prod2;
   logic [SUM1_W-1:0]             sum1;
   logic [SUM2_W-1:0]             sum2;
   logic [VQ_W-1:0]               hi;
   logic [VQ_W-1:0]               vq;
   logic [esr_pkg::VAR_W-1:0]     var_sat;
   logic [RES_W-1:0]              res_calc;
   logic [REM_W+1:0]              rem_shift;
   logic [REM_W+1:0]              sqrt_trial;
   logic                          sqrt_bit;
   logic [ROOT_W:0]               div_shift;
   logic                          div_bit;
   logic [RES_W-1:0]              res_abs;
   logic                          quo_sat;
   logic [STD_W-1:0]              std_val;
   logic                          ok;

   assign cnt_full = (cnt_ff == CNT_W'(MAX_CATEGORIES));
   assign prod1    = PW1'(cnt_ff) * PW1'(req_prob);
   assign prod2    = PW2'(ksq_ff) * PW2'(req_prob);
   assign sum1     = SUM1_W'(s1_ff) + SUM1_W'(prod1);
   assign sum2     = SUM2_W'(s2_ff) + SUM2_W'(prod2);

   always_comb begin
      cnt_in = cnt_ff;
      ksq_in = ksq_ff;
      s1_in  = s1_ff;
      s2_in  = s2_ff;
      ovf_in = ovf_ff;
      if (cmd.out_load) begin
         cnt_in = '0;
         ksq_in = '0;
         s1_in  = '0;
         s2_in  = '0;
         ovf_in = 1'b0;
      end else if (cmd.acc) begin
         if (cnt_full) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            ksq_in = ksq_ff + KSQ_W'({cnt_ff, 1'b1});
            s1_in  = (sum1 > SUM1_W'(esr_pkg::S1_MAX)) ? esr_pkg::S1_MAX
                                                       : sum1[esr_pkg::EXP_W-1:0];
            s2_in  = (sum2 > SUM2_W'(esr_pkg::S2_MAX)) ? esr_pkg::S2_MAX
                                                       : sum2[esr_pkg::S2_W-1:0];
         end
      end
   end

   // variance in Q.32, clamped at zero
   assign hi       = {s2_ff, {esr_pkg::FRAC_W{1'b0}}};
   assign vq       = (hi > sq_ff) ? (hi - sq_ff) : '0;
   assign var_sat  = (vq[VQ_W-1:VQ_W-2] != 2'b00) ? esr_pkg::VAR_MAX
                                                  : vq[VQ_W-3:esr_pkg::FRAC_W];
   assign res_calc = {1'b0, resp_ff, {esr_pkg::FRAC_W{1'b0}}} - {1'b0, s1_ff};

   // square root, two radicand bits per step
   assign rem_shift  = {rem_ff, rad_ff[VQ_W-1:VQ_W-2]};
   assign sqrt_trial = (REM_W+2)'({root_ff, 2'b01});
   assign sqrt_bit   = (rem_shift >= sqrt_trial);

   // restoring divide, one quotient bit per step
   assign div_shift = {drem_ff, num_ff[MAG_W-1]};
   assign div_bit   = (div_shift >= {1'b0, root_ff});

   assign res_abs  = res_ff[RES_W-1] ? (~res_ff + 1'b1) : res_ff;
   assign quo_sat  = (quo_ff >= MAG_W'(esr_pkg::STD_NEG_MAX));
   always_comb begin
      if (res_ff[RES_W-1]) begin
         std_val = quo_sat ? esr_pkg::STD_NEG_MAX : (~quo_ff[STD_W-1:0] + 1'b1);
      end else begin
         std_val = quo_sat ? esr_pkg::STD_POS_MAX : quo_ff[STD_W-1:0];
      end
   end

   assign ok = !tm_ff && !miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ksq_ff       <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ksq_ff <= ksq_in;
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         ovf_ff <= ovf_in;
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc && req_is_last) begin
         resp_ff <= req_response;
         miss_ff <= req_response_missing;
         tm_ff   <= ovf_ff || cnt_full;
      end
      if (cmd.square) begin
         sq_ff <= VQ_W'(s1_ff) * VQ_W'(s1_ff);
      end
      if (cmd.var_load) begin
         var_ff  <= var_sat;
         zv_ff   <= (vq == '0);
         res_ff  <= res_calc;
         rad_ff  <= vq;
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[VQ_W-3:0], 2'b00};
         rem_ff  <= sqrt_bit ? REM_W'(rem_shift - sqrt_trial) : rem_shift[REM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], sqrt_bit};
      end
      if (cmd.div_load) begin
         num_ff  <= {res_abs[ROOT_W-1:0], {esr_pkg::FRAC_W{1'b0}}};
         drem_ff <= '0;
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         num_ff  <= {num_ff[MAG_W-2:0], 1'b0};
         drem_ff <= div_bit ? ROOT_W'(div_shift - {1'b0, root_ff}) : div_shift[ROOT_W-1:0];
         quo_ff  <= {quo_ff[MAG_W-2:0], div_bit};
      end
      if (cmd.out_load) begin
         rsp_expected      <= ok ? s1_ff : '0;
         rsp_variance      <= ok ? var_ff : '0;
         rsp_residual      <= ok ? res_ff : '0;
         rsp_std_residual  <= (ok && !zv_ff) ? std_val : '0;
         rsp_missing       <= miss_ff;
         rsp_zero_variance <= ok && zv_ff;
         rsp_too_many      <= tm_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign status.last_skip = req_response_missing || ovf_ff || cnt_full;
   assign status.vq_zero   = (vq == '0);
   assign status.out_busy  = out_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

// ----- rtl/core/expected_score_residual.sv -----
// Top level of expected_score_residual: controller and datapath.
// Closing: a non-last request is absorbed on acceptance; a last request runs square,
// variance, a 20-step root and a 36-step divide before its result is registered; with zero
// variance root and divide are skipped, and with a missing response or a too-long run all are.
// Throughput: one request per cycle within a run, none while a run closes; a held result
// stalls the close. Synchronous active-high reset clears the run state and output valid.
`timescale 1ns / 1ps
`default_nettype none

module expected_score_residual #(
   parameter int MAX_CATEGORIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [esr_pkg::PROB_W-1:0]          req_prob,
   input  logic                                req_is_last,
   input  logic [esr_pkg::RESP_W-1:0]          req_response,
   input  logic                                req_response_missing,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [esr_pkg::EXP_W-1:0]           rsp_expected,
   output logic [esr_pkg::VAR_W-1:0]           rsp_variance,
   output logic signed [esr_pkg::RES_W-1:0]    rsp_residual,
   output logic signed [esr_pkg::STD_W-1:0]    rsp_std_residual,
   output logic                                rsp_missing,
   output logic                                rsp_zero_variance,
   output logic                                rsp_too_many
);

   esr_pkg::esr_cmd_type    cmd;
   esr_pkg::esr_status_type status;

   esr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_is_last),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   esr_dp #(
      .MAX_CATEGORIES (MAX_CATEGORIES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_prob             (req_prob),
      .req_is_last          (req_is_last),
      .req_response         (req_response),
      .req_response_missing (req_response_missing),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_expected         (rsp_expected),
      .rsp_variance         (rsp_variance),
      .rsp_residual         (rsp_residual),
      .rsp_std_residual     (rsp_std_residual),
      .rsp_missing          (rsp_missing),
      .rsp_zero_variance    (rsp_zero_variance),
      .rsp_too_many         (rsp_too_many)
   );

endmodule

`default_nettype wire

// ----- bench/expected_score_residual_test.sv -----
// Self-checking testbench for expected_score_residual: directed table plus random runs.
`timescale 1ns / 1ps

module expected_score_residual_test;

   localparam int MAX_CATEGORIES = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_REQUESTS = 475;
   localparam longint STD_TOP = (64'sd1 <<< (esr_pkg::STD_W - 1)) - 1;
   localparam longint STD_BOTTOM = -(64'sd1 <<< (esr_pkg::STD_W - 1));

   typedef struct packed {
      logic [esr_pkg::EXP_W-1:0] expected;
      logic [esr_pkg::VAR_W-1:0] variance;
      logic [esr_pkg::RES_W-1:0] residual;
      logic [esr_pkg::STD_W-1:0] std_residual;
      logic                      missing;
      logic                      zero_variance;
      logic                      too_many;
   } score_result_type;

   typedef struct packed {
      logic [4:0]                 copies;
      logic [esr_pkg::PROB_W-1:0] prob;
      logic                       is_last;
      logic [esr_pkg::RESP_W-1:0] response;
      logic                       missing;
      logic                       typed;
      score_result_type           want;
   } script_row_type;

   localparam score_result_type NO_RESULT = '0;
   localparam int SCRIPT_ROWS = 11;

   // copies, prob, last, response, missing, typed, result
   script_row_type script [SCRIPT_ROWS] = '{
      '{5'd1, 17'h10000, 1'b1, 4'd15, 1'b0, 1'b1,
        '{20'd0, 22'd0, 21'd983040, 24'd0, 1'b0, 1'b1, 1'b0}},
      '{5'd1, 17'h00000, 1'b1, 4'd15, 1'b1, 1'b1,
        '{20'd0, 22'd0, 21'd0, 24'd0, 1'b1, 1'b0, 1'b0}},
      '{5'd1, 17'h08000, 1'b0, 4'd0, 1'b0, 1'b0, NO_RESULT},
      '{5'd1, 17'h08000, 1'b1, 4'd1, 1'b0, 1'b1,
        '{20'd32768, 22'd16384, 21'd32768, 24'd65536, 1'b0, 1'b0, 1'b0}},
      // run one past the category limit, sums saturate on the way
      '{5'd16, 17'h1FFFF, 1'b0, 4'd15, 1'b1, 1'b0, NO_RESULT},
      '{5'd1, 17'h1FFFF, 1'b1, 4'd15, 1'b0, 1'b1,
        '{20'd0, 22'd0, 21'd0, 24'd0, 1'b0, 1'b0, 1'b1}},
      // mass above one: variance goes negative and clamps
      '{5'd1, 17'h00000, 1'b0, 4'd0, 1'b0, 1'b0, NO_RESULT},
      '{5'd1, 17'h1FFFF, 1'b1, 4'd0, 1'b0, 1'b0, NO_RESULT},
      // tiny spread: std residual saturates high
      '{5'd1, 17'h00000, 1'b0, 4'd10, 1'b0, 1'b0, NO_RESULT},
      '{5'd1, 17'h0FFFF, 1'b0, 4'd5, 1'b1, 1'b0, NO_RESULT},
      '{5'd1, 17'h00001, 1'b1, 4'd15, 1'b0, 1'b1,
        '{20'd65537, 22'd0, 21'd917503, esr_pkg::STD_POS_MAX, 1'b0, 1'b0, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [esr_pkg::PROB_W-1:0] req_prob;
   logic req_is_last;
   logic [esr_pkg::RESP_W-1:0] req_response;
   logic req_response_missing;
   logic rsp_valid;
   logic rsp_ready;
   logic [esr_pkg::EXP_W-1:0] rsp_expected;
   logic [esr_pkg::VAR_W-1:0] rsp_variance;
   logic signed [esr_pkg::RES_W-1:0] rsp_residual;
   logic signed [esr_pkg::STD_W-1:0] rsp_std_residual;
   logic rsp_missing;
   logic rsp_zero_variance;
   logic rsp_too_many;

   score_result_type expected_scores [$];

   int run_length;
   longint run_sum;
   longint run_square_sum;
   bit run_overflow;

   int send_idle_pct;
   int recv_idle_pct;
   int request_count;
   int run_count;
   int result_count;
   int too_many_count;
   int missing_count;
   int zero_variance_count;
   int mismatch_count;
   int stall_cycles;

   expected_score_residual #(
      .MAX_CATEGORIES(MAX_CATEGORIES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_prob(req_prob),
      .req_is_last(req_is_last),
      .req_response(req_response),
      .req_response_missing(req_response_missing),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_expected(rsp_expected),
      .rsp_variance(rsp_variance),
      .rsp_residual(rsp_residual),
      .rsp_std_residual(rsp_std_residual),
      .rsp_missing(rsp_missing),
      .rsp_zero_variance(rsp_zero_variance),
      .rsp_too_many(rsp_too_many)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Accumulates one category; returns 1 with the score when the run closes.
   function automatic bit predict_item_score(input logic [esr_pkg::PROB_W-1:0] prob,
         input logic is_last, input logic [esr_pkg::RESP_W-1:0] response,
         input logic missing, output score_result_type score);
      longint k;
      longint var_q32;
      longint root;
      longint trial;
      longint resid;
      longint quot;
      longint std_val;
      score = '0;
      if (run_length >= MAX_CATEGORIES) begin
         run_overflow = 1'b1;
      end else begin
         k = run_length;
         run_sum = run_sum + k * longint'(prob);
         if (run_sum > longint'(esr_pkg::S1_MAX)) run_sum = longint'(esr_pkg::S1_MAX);
         run_square_sum = run_square_sum + k * k * longint'(prob);
         if (run_square_sum > longint'(esr_pkg::S2_MAX))
            run_square_sum = longint'(esr_pkg::S2_MAX);
         run_length++;
      end
      if (!is_last) return 1'b0;

      score.missing = missing;
      score.too_many = run_overflow;
      if (!run_overflow && !missing) begin
         var_q32 = (run_square_sum <<< esr_pkg::FRAC_W) - run_sum * run_sum;
         if (var_q32 < 0) var_q32 = 0;
         score.expected = run_sum[esr_pkg::EXP_W-1:0];
         if ((var_q32 >>> esr_pkg::FRAC_W) > longint'(esr_pkg::VAR_MAX))
            score.variance = esr_pkg::VAR_MAX;
         else
            score.variance = var_q32[esr_pkg::FRAC_W +: esr_pkg::VAR_W];
         resid = (longint'(response) <<< esr_pkg::FRAC_W) - run_sum;
         score.residual = resid[esr_pkg::RES_W-1:0];
         if (var_q32 == 0) begin
            score.zero_variance = 1'b1;
         end else begin
            root = 0;
            for (int b = 21; b >= 0; b--) begin
               trial = root | (64'sd1 <<< b);
               if (trial * trial <= var_q32) root = trial;
            end
            quot = ((resid < 0 ? -resid : resid) <<< esr_pkg::FRAC_W) / root;
            if (quot > STD_TOP + 1) quot = STD_TOP + 1;
            std_val = resid < 0 ? -quot : quot;
            if (std_val > STD_TOP) std_val = STD_TOP;
            if (std_val < STD_BOTTOM) std_val = STD_BOTTOM;
            score.std_residual = std_val[esr_pkg::STD_W-1:0];
         end
      end
      run_length = 0;
      run_sum = 0;
      run_square_sum = 0;
      run_overflow = 1'b0;
      return 1'b1;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic push_request(input logic [esr_pkg::PROB_W-1:0] prob, input logic is_last,
         input logic [esr_pkg::RESP_W-1:0] response, input logic missing,
         input bit typed, input score_result_type want);
      score_result_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_prob <= prob;
      req_is_last <= is_last;
      req_response <= response;
      req_response_missing <= missing;
      do @(posedge clock); while (!req_ready);
      request_count++;
      if (predict_item_score(prob, is_last, response, missing, predicted)) begin
         expected_scores.push_back(typed ? want : predicted);
         run_count++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_scores.size() != 0);
   endtask

   // Mostly proper distributions; noisy runs may exceed one or run too long.
   task automatic send_run(input bit noisy);
      int n;
      int remaining;
      int p;
      bit miss;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_CATEGORIES) :
                                        $urandom_range(2, 5);
      if (noisy) n = $urandom_range(1, MAX_CATEGORIES + 4);
      miss = noisy ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) == 0);
      remaining = 1 << esr_pkg::FRAC_W;
      for (int i = 0; i < n; i++) begin
         if (noisy) p = $urandom_range(0, (1 << esr_pkg::PROB_W) - 1);
         else if (i == n - 1) p = remaining;
         else p = $urandom_range(0, remaining);
         remaining -= (noisy ? 0 : p);
         if (i == n - 1)
            push_request(p[esr_pkg::PROB_W-1:0], 1'b1,
                         esr_pkg::RESP_W'($urandom_range(0, 15)), miss, 1'b0, NO_RESULT);
         else
            push_request(p[esr_pkg::PROB_W-1:0], 1'b0,
                         esr_pkg::RESP_W'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      end
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want_v,
         input logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : score_check
      score_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scores.size() == 0) begin
            $display("%0t: result with none expected, expected none, actual %0d",
                     $time, rsp_expected);
            mismatch_count++;
         end else begin
            want = expected_scores.pop_front();
            result_count++;
            too_many_count += int'(want.too_many);
            missing_count += int'(want.missing);
            zero_variance_count += int'(want.zero_variance);
            check_field("expected", 64'(want.expected), 64'(rsp_expected));
            check_field("variance", 64'(want.variance), 64'(rsp_variance));
            check_field("residual", 64'($signed(want.residual)), 64'(rsp_residual));
            check_field("std_residual", 64'($signed(want.std_residual)),
                        64'(rsp_std_residual));
            check_field("missing", 64'(want.missing), 64'(rsp_missing));
            check_field("zero_variance", 64'(want.zero_variance), 64'(rsp_zero_variance));
            check_field("too_many", 64'(want.too_many), 64'(rsp_too_many));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no request or result moved for %0d cycles",
                  $time, STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int send_idle_by_phase [3];
      int recv_idle_by_phase [3];
      int phase_target;
      send_idle_by_phase = '{9, 67, 0};
      recv_idle_by_phase = '{67, 9, 0};
      reset = 1'b1;
      req_valid = 1'b0;
      req_prob = '0;
      req_is_last = 1'b0;
      req_response = '0;
      req_response_missing = 1'b0;
      rsp_ready = 1'b0;
      run_length = 0;
      run_sum = 0;
      run_square_sum = 0;
      run_overflow = 1'b0;
      request_count = 0;
      run_count = 0;
      result_count = 0;
      too_many_count = 0;
      missing_count = 0;
      zero_variance_count = 0;
      mismatch_count = 0;
      stall_cycles = 0;
      send_idle_pct = send_idle_by_phase[0];
      recv_idle_pct = recv_idle_by_phase[0];
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         repeat (script[i].copies)
            push_request(script[i].prob, script[i].is_last, script[i].response,
                         script[i].missing, script[i].typed, script[i].want);

      for (int phase = 0; phase < 3; phase++) begin
         wait_drained();
         send_idle_pct = send_idle_by_phase[phase];
         recv_idle_pct = recv_idle_by_phase[phase];
         phase_target = request_count + PHASE_REQUESTS;
         while (request_count < phase_target) begin
            send_run($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 39) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d requests in %0d runs under three idle patterns; %0d results checked",
               request_count, run_count, result_count);
      $display("Flagged results: %0d too many categories, %0d missing, %0d zero variance",
               too_many_count, missing_count, zero_variance_count);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/esr_pkg.sv
rtl/core/esr_ctrl.sv
rtl/core/esr_dp.sv
rtl/core/expected_score_residual.sv
bench/expected_score_residual_test.sv
